// File: rtl/moving_average_step_bypass_unit_defines.svh
// Assertion helpers for the moving average unit.
`ifndef MOVING_AVERAGE_STEP_BYPASS_UNIT_DEFINES_SVH
`define MOVING_AVERAGE_STEP_BYPASS_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MASB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MASB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/masb_pkg.sv
package masb_pkg;

  localparam int SAMPLE_W   = 25;
  localparam int THR_W      = 25;
  localparam int LOG2_W     = 3;
  localparam int MAX_LOG2   = 5;
  localparam int RING_DEPTH = 1 << MAX_LOG2;
  localparam int IDX_W      = MAX_LOG2;
  localparam int SUM_W      = SAMPLE_W + MAX_LOG2;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CNT_W-1:0]  STEP_LIMIT  = 3'd3;
  localparam logic [CNT_W-1:0]  CNT_MAX     = 3'd7;
  localparam logic [LOG2_W-1:0] WIN_RESET   = 3'd3;
  localparam logic [THR_W-1:0]  THR_RESET   = 25'd1000;

  typedef enum logic {
    CMD_FILTER  = 1'b0,
    CMD_PRELOAD = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LOG2    = 1'b0,
    REG_JUMP_THRESHOLD = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_ACC,
    ST_SHIFT,
    ST_FILL,
    ST_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic eval;
    logic acc;
    logic shift;
    logic fill;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic go_fill;
    logic fill_last;
  } dp_stat_t;

endpackage

// File: rtl/moving_average_step_bypass_unit.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_ready_o   cmd_i, sample_i
// out      output     out_valid_o/out_ready_i average_o, bypassed_o
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A filter request steps through accept, compare/count, ring
// read-modify-write, shift and result load before the next free slot.
// A preload or a step refill sweeps the window instead, one entry per
// cycle through the single ring write port.
// One request is in flight at a time; the result register lets a new
// request in while an older result waits on out_ready_i.
// Reset is asynchronous; ring entries hold no reset, valid bits mark them.
`include "moving_average_step_bypass_unit_defines.svh"

module moving_average_step_bypass_unit
  import masb_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic signed [SAMPLE_W-1:0]  sample_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [SAMPLE_W-1:0]  average_o,
  output logic                        bypassed_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [THR_W-1:0]            cfg_data_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Register writes are always taken and go straight into the config registers.
  assign cfg_ready_o = 1'b1;

  masb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  masb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_cmd_i    (cmd_i),
    .in_sample_i (sample_i),
    .average_o   (average_o),
    .bypassed_o  (bypassed_o)
  );

  // A request is never followed by another one in the next cycle.
  `MASB_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "overlapping requests")

  // A new result appears exactly as the block returns to idle.
  `MASB_ASSERT_NOW(a_result_at_idle, $rose(out_valid_o), in_ready_o, "result outside finish")

endmodule

// File: rtl/masb_dp.sv
module masb_dp
  import masb_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dp_cmd_t                     cmd_i,
  output dp_stat_t                    stat_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [THR_W-1:0]            cfg_data_i,
  input  logic                        in_cmd_i,
  input  logic signed [SAMPLE_W-1:0]  in_sample_i,
  output logic signed [SAMPLE_W-1:0]  average_o,
  output logic                        bypassed_o
);

  logic [LOG2_W-1:0]          win_q;
  logic [THR_W-1:0]           thr_q;

  logic                       cmd_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic [IDX_W-1:0]           wr_idx_q;
  logic [CNT_W-1:0]           cnt_q;
  logic signed [SAMPLE_W-1:0] last_q;
  logic                       bypass_q;
  logic [IDX_W-1:0]           fill_idx_q;

  logic signed [SAMPLE_W-1:0] ring_q [RING_DEPTH];
  logic [RING_DEPTH-1:0]      vld_q;
  logic signed [SAMPLE_W-1:0] rd_q;
  logic                       rd_vld_q;

  logic signed [SAMPLE_W-1:0] average_q;
  logic                       bypassed_q;

  logic [LOG2_W-1:0]          eff_k;
  logic [IDX_W:0]             win_len;
  logic [IDX_W-1:0]           len_m1;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          abs_diff;
  logic                       over;
  logic [CNT_W-1:0]           cnt_nxt;
  logic signed [SUM_W-1:0]    sample_ext;
  logic signed [SUM_W-1:0]    old_ext;
  logic signed [SUM_W-1:0]    sum_shr;
  logic [IDX_W:0]             idx_inc;
  logic                       mem_we;
  logic [IDX_W-1:0]           mem_addr;

  // Windows above the ring size act as the full ring
  assign eff_k   = (win_q > LOG2_W'(MAX_LOG2)) ? LOG2_W'(MAX_LOG2) : win_q;
  assign win_len = (IDX_W+1)'(1) << eff_k;
  assign len_m1  = IDX_W'(win_len - (IDX_W+1)'(1));

  assign diff     = {sample_q[SAMPLE_W-1], sample_q} - {last_q[SAMPLE_W-1], last_q};
  assign abs_diff = diff[SAMPLE_W] ? unsigned'(-diff) : unsigned'(diff);
  assign over     = abs_diff > {1'b0, thr_q};
  assign cnt_nxt  = over ? ((cnt_q == CNT_MAX) ? cnt_q : cnt_q + CNT_W'(1)) : '0;

  assign sample_ext = {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
  assign old_ext    = rd_vld_q ? {{(SUM_W-SAMPLE_W){rd_q[SAMPLE_W-1]}}, rd_q} : '0;
  assign sum_shr    = sum_q >>> eff_k;
  assign idx_inc    = {1'b0, wr_idx_q} + (IDX_W+1)'(1);

  assign stat_o.go_fill   = (cmd_e'(cmd_q) == CMD_PRELOAD) || (cnt_nxt > STEP_LIMIT);
  assign stat_o.fill_last = (fill_idx_q == len_m1);

  assign mem_we   = cmd_i.acc || cmd_i.fill;
  assign mem_addr = cmd_i.fill ? fill_idx_q : wr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_RESET;
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_WINDOW_LOG2:    win_q <= cfg_data_i[LOG2_W-1:0];
        REG_JUMP_THRESHOLD: thr_q <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      wr_idx_q   <= '0;
      cnt_q      <= '0;
      last_q     <= '0;
      bypass_q   <= 1'b0;
      fill_idx_q <= '0;
      vld_q      <= '0;
    end else begin
      if (cmd_i.capture) begin
        fill_idx_q <= '0;
      end
      if (cmd_i.eval) begin
        if (cmd_e'(cmd_q) == CMD_FILTER) begin
          cnt_q    <= cnt_nxt;
          bypass_q <= cnt_nxt > STEP_LIMIT;
        end else begin
          bypass_q <= 1'b0;
        end
      end
      if (cmd_i.acc) begin
        sum_q    <= sum_q + sample_ext - old_ext;
        wr_idx_q <= (idx_inc >= win_len) ? '0 : idx_inc[IDX_W-1:0];
      end
      if (cmd_i.shift) begin
        last_q <= sum_shr[SAMPLE_W-1:0];
      end
      if (cmd_i.fill) begin
        sum_q      <= sample_ext << eff_k;
        fill_idx_q <= fill_idx_q + IDX_W'(1);
        if (bypass_q) begin
          last_q <= sample_q;
        end
      end
      if (mem_we) begin
        vld_q[mem_addr] <= 1'b1;
      end
    end
  end

  // Ring storage and registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[mem_addr] <= sample_q;
    end
    rd_q     <= ring_q[wr_idx_q];
    rd_vld_q <= vld_q[wr_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= in_cmd_i;
      sample_q <= in_sample_i;
    end
    if (cmd_i.load_out) begin
      average_q  <= last_q;
      bypassed_q <= bypass_q;
    end
  end

  assign average_o  = average_q;
  assign bypassed_o = bypassed_q;

endmodule

// File: rtl/masb_ctrl.sv
module masb_ctrl
  import masb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   room;

  assign room = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL:   state_d = stat_i.go_fill ? ST_FILL : ST_ACC;
      ST_ACC:    state_d = ST_SHIFT;
      ST_SHIFT:  state_d = ST_FINISH;
      ST_FILL:   if (stat_i.fill_last) state_d = ST_FINISH;
      ST_FINISH: if (room) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = (state_q == ST_IDLE);
    cmd_o.capture    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.eval       = (state_q == ST_EVAL);
    cmd_o.acc        = (state_q == ST_ACC);
    cmd_o.shift      = (state_q == ST_SHIFT);
    cmd_o.fill       = (state_q == ST_FILL);
    cmd_o.load_out   = (state_q == ST_FINISH) && room;
    out_valid_d      = cmd_o.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
